/* design/assert_macros.svh */
// Assertion macros used by the checker file dmhq_checker.sv.
// Each macro clocks on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define AST_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dmhq_pkg.sv */
// Package for the deadline min-heap queue: request kinds, status codes,
// controller states, cell commands and the cell flag bundle. No dependencies.
`default_nettype none

package dmhq_pkg;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    // fixed port field widths
    localparam int TASK_W  = 6;
    localparam int COUNT_W = 6;
    localparam int DL_W    = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_EXEC,
        S_RESIFT,
        S_UP,
        S_DOWN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_SWAP
    } t_cell_op;

    // per-cell status seen by the controller
    typedef struct packed {
        logic match;      // holds the looked-up task and is inside the heap
        logic lt_parent;  // key below the parent's key
        logic dn_swap;    // sift-down step from here would swap
        logic dn_left;    // that step takes the left child
    } t_cell_flags;

endpackage

`default_nettype wire

/* design/deadline_min_heap_queue.sv */
// Each request runs idle (capture), find (task lookup) and exec (write or reject);
// an accepted insert then sifts up, an update or a non-last remove re-sifts up or
// down, and every request ends in out. One request at a time: the next input beat
// is taken only in idle, once the result beat has registered (plus stalls).
// Sync active-low reset empties the heap and clears control; slot data is not reset.
// Top level of the deadline min-heap queue; uses dmhq_pkg and dmhq_cell.
`default_nettype none

module deadline_min_heap_queue #(
    parameter int MAX_ENTRIES   = 32,
    parameter int TASK_IDS      = 64,
    parameter int DEADLINE_BITS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [71:0] i_s_tdata,   // task_id[5:0], deadline[69:6], zero pad
    input  wire  [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [79:0] o_m_tdata    // status[1:0], entry_count[7:2], top_valid[8],
                                     // top_task[14:9], top_deadline[78:15], pad[79]
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = dmhq_pkg::TASK_W;

    dmhq_pkg::t_state r_state, n_state;

    logic [1:0]               r_kind;
    logic [TW-1:0]            r_tid;
    logic [DEADLINE_BITS-1:0] r_dl;
    logic [CW-1:0]            r_count;
    logic [IW-1:0]            r_cur;
    logic                     r_found;
    logic [IW-1:0]            r_fidx;
    logic [1:0]               r_status;
    logic                     r_m_valid;
    logic [79:0]              r_m_data;

    // cell command
    dmhq_pkg::t_cell_op       w_op;
    logic [IW-1:0]            w_a, w_b;
    logic [TW-1:0]            w_wr_task;
    logic [DEADLINE_BITS-1:0] w_wr_dl;

    logic [TW-1:0]            w_task [MAX_ENTRIES];
    logic [DEADLINE_BITS-1:0] w_dl   [MAX_ENTRIES];
    dmhq_pkg::t_cell_flags    w_flags[MAX_ENTRIES];

    logic                     w_any;
    logic [IW-1:0]            w_midx;
    logic                     w_id_ok, w_present, w_full;
    logic [CW-1:0]            w_cnt_dec;
    logic [IW-1:0]            w_last;
    logic [IW-1:0]            w_parent;
    logic [IW:0]              w_child;
    logic                     w_up_go, w_dn_go;
    logic                     w_out_free;
    logic [70:0]              w_top;

    // row of slot cells
    for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
        localparam int PJ = (j == 0) ? 0 : (j - 1) / 2;
        logic [TW-1:0]            w_lt, w_rt;
        logic [DEADLINE_BITS-1:0] w_ld, w_rdl;
        if (2 * j + 1 < MAX_ENTRIES) begin : g_l
            assign w_lt = w_task[2*j+1];
            assign w_ld = w_dl[2*j+1];
        end else begin : g_nl
            assign w_lt = '0;
            assign w_ld = '0;
        end
        if (2 * j + 2 < MAX_ENTRIES) begin : g_r
            assign w_rt  = w_task[2*j+2];
            assign w_rdl = w_dl[2*j+2];
        end else begin : g_nr
            assign w_rt  = '0;
            assign w_rdl = '0;
        end
        dmhq_cell #(
            .IDX         (j),
            .DL_BITS     (DEADLINE_BITS),
            .IW          (IW),
            .CW          (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (w_op),
            .i_a        (w_a),
            .i_b        (w_b),
            .i_wr_task  (w_wr_task),
            .i_wr_dl    (w_wr_dl),
            .i_tid      (r_tid),
            .i_count    (r_count),
            .i_par_task (w_task[PJ]),
            .i_par_dl   (w_dl[PJ]),
            .i_l_task   (w_lt),
            .i_l_dl     (w_ld),
            .i_r_task   (w_rt),
            .i_r_dl     (w_rdl),
            .o_task     (w_task[j]),
            .o_dl       (w_dl[j]),
            .o_flags    (w_flags[j])
        );
    end

    // task lookup: encode the matching slot
    always_comb begin
        w_any  = 1'b0;
        w_midx = '0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (w_flags[j].match) begin
                w_any  = 1'b1;
                w_midx = w_midx | IW'(j);
            end
        end
    end

    // request decode helpers
    always_comb begin
        w_id_ok    = 32'(r_tid) < 32'(TASK_IDS);
        w_present  = r_found && w_id_ok;
        w_full     = r_count >= CW'(MAX_ENTRIES);
        w_cnt_dec  = r_count - CW'(1);
        w_last     = w_cnt_dec[IW-1:0];
        w_parent   = (r_cur - IW'(1)) >> 1;
        w_child    = {r_cur, 1'b0} + (w_flags[r_cur].dn_left ? (IW+1)'(1) : (IW+1)'(2));
        w_up_go    = (r_cur != '0) && w_flags[r_cur].lt_parent;
        w_dn_go    = w_flags[r_cur].dn_swap;
        w_out_free = !r_m_valid || i_m_tready;
        w_top      = (r_count != '0) ? {dmhq_pkg::DL_W'(w_dl[0]), w_task[0], 1'b1} : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmhq_pkg::S_IDLE:   if (i_s_tvalid) n_state = dmhq_pkg::S_FIND;
            dmhq_pkg::S_FIND:   n_state = dmhq_pkg::S_EXEC;
            dmhq_pkg::S_EXEC: begin
                n_state = dmhq_pkg::S_OUT;
                case (r_kind)
                    dmhq_pkg::KIND_INSERT:
                        if (!w_full && w_id_ok && !w_present) n_state = dmhq_pkg::S_UP;
                    dmhq_pkg::KIND_REMOVE:
                        if (w_present && ({1'b0, r_fidx} < w_cnt_dec))
                            n_state = dmhq_pkg::S_RESIFT;
                    dmhq_pkg::KIND_UPDATE:
                        if (w_present) n_state = dmhq_pkg::S_RESIFT;
                    default: ;
                endcase
            end
            dmhq_pkg::S_RESIFT: n_state = w_up_go ? dmhq_pkg::S_UP : dmhq_pkg::S_DOWN;
            dmhq_pkg::S_UP:     if (!w_up_go) n_state = dmhq_pkg::S_OUT;
            dmhq_pkg::S_DOWN:   if (!w_dn_go) n_state = dmhq_pkg::S_OUT;
            dmhq_pkg::S_OUT:    if (w_out_free) n_state = dmhq_pkg::S_IDLE;
            default:            n_state = dmhq_pkg::S_IDLE;
        endcase
    end

    // outputs: handshake and cell command
    always_comb begin
        o_s_tready = 1'b0;
        w_op       = dmhq_pkg::OP_HOLD;
        w_a        = r_cur;
        w_b        = r_cur;
        w_wr_task  = r_tid;
        w_wr_dl    = r_dl;
        unique case (r_state)
            dmhq_pkg::S_IDLE: o_s_tready = 1'b1;
            dmhq_pkg::S_EXEC: begin
                case (r_kind)
                    dmhq_pkg::KIND_INSERT: begin
                        if (!w_full && w_id_ok && !w_present) begin
                            w_op = dmhq_pkg::OP_WRITE;
                            w_a  = r_count[IW-1:0];
                        end
                    end
                    dmhq_pkg::KIND_REMOVE: begin
                        if (w_present && ({1'b0, r_fidx} < w_cnt_dec)) begin
                            w_op      = dmhq_pkg::OP_WRITE;
                            w_a       = r_fidx;
                            w_wr_task = w_task[w_last];
                            w_wr_dl   = w_dl[w_last];
                        end
                    end
                    dmhq_pkg::KIND_UPDATE: begin
                        if (w_present) begin
                            w_op = dmhq_pkg::OP_WRITE;
                            w_a  = r_fidx;
                        end
                    end
                    default: ;
                endcase
            end
            dmhq_pkg::S_UP: begin
                if (w_up_go) begin
                    w_op = dmhq_pkg::OP_SWAP;
                    w_b  = w_parent;
                end
            end
            dmhq_pkg::S_DOWN: begin
                if (w_dn_go) begin
                    w_op = dmhq_pkg::OP_SWAP;
                    w_b  = w_child[IW-1:0];
                end
            end
            default: ;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dmhq_pkg::S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // result valid: set on a new result, cleared when taken
            if (r_state == dmhq_pkg::S_OUT && w_out_free) r_m_valid <= 1'b1;
            else if (i_m_tready)                          r_m_valid <= 1'b0;
            case (r_state)
                dmhq_pkg::S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind <= i_s_tuser;
                        r_tid  <= i_s_tdata[TW-1:0];
                        r_dl   <= i_s_tdata[TW +: DEADLINE_BITS];
                    end
                end
                dmhq_pkg::S_FIND: begin
                    r_found <= w_any;
                    r_fidx  <= w_midx;
                end
                dmhq_pkg::S_EXEC: begin
                    case (r_kind)
                        dmhq_pkg::KIND_INSERT: begin
                            if (w_full) begin
                                r_status <= dmhq_pkg::ST_FULL;
                            end else if (!w_id_ok) begin
                                r_status <= dmhq_pkg::ST_ABSENT;
                            end else if (w_present) begin
                                r_status <= dmhq_pkg::ST_PRESENT;
                            end else begin
                                r_status <= dmhq_pkg::ST_OK;
                                r_cur    <= r_count[IW-1:0];
                                r_count  <= r_count + CW'(1);
                            end
                        end
                        dmhq_pkg::KIND_REMOVE: begin
                            if (!w_present) begin
                                r_status <= dmhq_pkg::ST_ABSENT;
                            end else begin
                                r_status <= dmhq_pkg::ST_OK;
                                r_count  <= w_cnt_dec;
                                r_cur    <= r_fidx;
                            end
                        end
                        dmhq_pkg::KIND_UPDATE: begin
                            if (!w_present) begin
                                r_status <= dmhq_pkg::ST_ABSENT;
                            end else begin
                                r_status <= dmhq_pkg::ST_OK;
                                r_cur    <= r_fidx;
                            end
                        end
                        default: r_status <= dmhq_pkg::ST_OK;
                    endcase
                end
                dmhq_pkg::S_UP:   if (w_up_go) r_cur <= w_parent;
                dmhq_pkg::S_DOWN: if (w_dn_go) r_cur <= w_child[IW-1:0];
                dmhq_pkg::S_OUT: begin
                    if (w_out_free) begin
                        r_m_data <= {1'b0, w_top, dmhq_pkg::COUNT_W'(r_count), r_status};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

/* design/dmhq_cell.sv */
// One heap slot: task id and deadline, local compares against its parent
// and children, a direct write, and neighbor exchange on swap. Uses dmhq_pkg.
`default_nettype none

module dmhq_cell #(
    parameter int IDX         = 0,
    parameter int DL_BITS     = 64,
    parameter int IW          = 5,
    parameter int CW          = 6
) (
    input  wire                       i_clk,
    input  dmhq_pkg::t_cell_op        i_op,
    input  wire [IW-1:0]              i_a,
    input  wire [IW-1:0]              i_b,
    input  wire [dmhq_pkg::TASK_W-1:0] i_wr_task,
    input  wire [DL_BITS-1:0]         i_wr_dl,
    input  wire [dmhq_pkg::TASK_W-1:0] i_tid,
    input  wire [CW-1:0]              i_count,
    input  wire [dmhq_pkg::TASK_W-1:0] i_par_task,
    input  wire [DL_BITS-1:0]         i_par_dl,
    input  wire [dmhq_pkg::TASK_W-1:0] i_l_task,
    input  wire [DL_BITS-1:0]         i_l_dl,
    input  wire [dmhq_pkg::TASK_W-1:0] i_r_task,
    input  wire [DL_BITS-1:0]         i_r_dl,
    output logic [dmhq_pkg::TASK_W-1:0] o_task,
    output logic [DL_BITS-1:0]        o_dl,
    output dmhq_pkg::t_cell_flags     o_flags
);

    localparam int PAR = (IDX == 0) ? 0 : (IDX - 1) / 2;
    localparam logic [IW:0] SELF_V = (IW+1)'(IDX);
    localparam logic [IW:0] PAR_V  = (IW+1)'(PAR);
    localparam logic [IW:0] LI_V   = (IW+1)'(2 * IDX + 1);
    localparam logic [CW:0] LI_C   = (CW+1)'(2 * IDX + 1);
    localparam logic [CW:0] RI_C   = (CW+1)'(2 * IDX + 2);

    logic [dmhq_pkg::TASK_W-1:0] r_task, n_task;
    logic [DL_BITS-1:0]          r_dl, n_dl;
    logic [IW:0]                 w_other;
    logic                        w_hit;
    logic                        w_have_l, w_have_r;
    logic [DL_BITS-1:0]          w_rd;

    // swap partner of this slot, if any
    always_comb begin
        w_hit   = 1'b0;
        w_other = '0;
        if ({1'b0, i_a} == SELF_V) begin
            w_hit   = 1'b1;
            w_other = {1'b0, i_b};
        end else if ({1'b0, i_b} == SELF_V) begin
            w_hit   = 1'b1;
            w_other = {1'b0, i_a};
        end
    end

    // next slot contents
    always_comb begin
        n_task = r_task;
        n_dl   = r_dl;
        case (i_op)
            dmhq_pkg::OP_WRITE: begin
                if ({1'b0, i_a} == SELF_V) begin
                    n_task = i_wr_task;
                    n_dl   = i_wr_dl;
                end
            end
            dmhq_pkg::OP_SWAP: begin
                if (w_hit) begin
                    if (IDX != 0 && w_other == PAR_V) begin
                        n_task = i_par_task;
                        n_dl   = i_par_dl;
                    end else if (w_other == LI_V) begin
                        n_task = i_l_task;
                        n_dl   = i_l_dl;
                    end else begin
                        n_task = i_r_task;
                        n_dl   = i_r_dl;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
        r_dl   <= n_dl;
    end

    // local compares; ties in sift-down go right
    always_comb begin
        w_have_l = {1'b0, i_count} > LI_C;
        w_have_r = {1'b0, i_count} > RI_C;
        w_rd     = w_have_r ? i_r_dl : r_dl;
        o_flags.match     = (r_task == i_tid) && ({1'b0, i_count} > (CW+1)'(IDX));
        o_flags.lt_parent = (IDX != 0) && (r_dl < i_par_dl);
        o_flags.dn_left   = w_have_r ? (i_l_dl < i_r_dl) : 1'b1;
        o_flags.dn_swap   = w_have_l && ((r_dl > i_l_dl) || (r_dl > w_rd));
    end

    assign o_task = r_task;
    assign o_dl   = r_dl;

endmodule

`default_nettype wire

/* design/dmhq_checker.sv */
// Port-level checker for deadline_min_heap_queue, attached by bind.
// Uses dmhq_pkg and the macros of assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dmhq_checker #(
    parameter int MAX_ENTRIES = 32
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [79:0] o_m_tdata
);

    // a stalled result beat holds
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")
    // top valid tracks a nonzero count
    `AST_IMPL(a_topv, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[8] == (o_m_tdata[7:2] != 6'd0), "top_valid disagrees with entry_count")
    // full status only with a full heap
    `AST_IMPL(a_full, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[1:0] == dmhq_pkg::ST_FULL), o_m_tdata[7:2] == 6'(MAX_ENTRIES), "full status with room left")
    // empty heap shows a cleared top
    `AST_IMPL(a_empty, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[8], o_m_tdata[79:9] == '0, "empty heap shows a top entry")

endmodule

bind deadline_min_heap_queue dmhq_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_dmhq_checker (.*);

`default_nettype wire
